### rtl/core/tmrq_pkg.sv
`default_nettype none
package tmrq_pkg;

  localparam int SLOTS       = 64;
  localparam int HANDLE_BITS = 16;
  localparam int RANK_BITS   = 16;
  localparam int COMM_BITS   = 16;
  localparam int TAG_BITS    = 32;
  localparam int KEY_W       = COMM_BITS + RANK_BITS + TAG_BITS;
  localparam int CNT_W       = $clog2(SLOTS + 1);

  typedef logic [KEY_W-1:0]       key_t;
  typedef logic [HANDLE_BITS-1:0] handle_t;
  typedef logic [CNT_W-1:0]       count_t;

  typedef enum logic [0:0] {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [15:0]        comm_id;
    logic [15:0]        source_rank;
    logic signed [31:0] msg_tag;
    logic [15:0]        request_handle;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [15:0] found_handle;
    logic [6:0]  pending_count;
  } rsp_t;

  // per-cell view for the sweep control
  typedef struct packed {
    logic tok;
    logic valid;
    logic acc;
    logic hit;
  } cell_stat_t;

  function automatic key_t make_key(input req_t r);
    make_key = {r.comm_id[COMM_BITS-1:0], r.source_rank[RANK_BITS-1:0],
                r.msg_tag[TAG_BITS-1:0]};
  endfunction

endpackage
`default_nettype wire

### rtl/core/tmrq_cell.sv
`default_nettype none
module tmrq_cell
  import tmrq_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       enq_we,
  input  wire key_t       enq_key,
  input  wire handle_t    enq_handle,
  input  wire key_t       qry_key,
  input  wire logic       prev_valid,
  input  wire logic       tok_in,
  input  wire logic       fnd_in,
  input  wire logic       nxt_valid,
  input  wire key_t       nxt_key,
  input  wire handle_t    nxt_handle,
  output logic            tok_out,
  output logic            fnd_out,
  output logic            valid,
  output key_t            key,
  output handle_t         handle,
  output cell_stat_t      stat
);

  logic tok;
  logic fnd;
  logic match;
  logic acc;
  logic shift;
  logic write;

  assign match   = tok && valid && (key == qry_key);
  assign acc     = fnd || match;
  assign shift   = tok && valid && acc;
  assign write   = enq_we && !valid && prev_valid;
  assign tok_out = tok && valid;
  assign fnd_out = acc;

  assign stat.tok   = tok;
  assign stat.valid = valid;
  assign stat.acc   = tok && acc;
  assign stat.hit   = match && !fnd;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      tok   <= 1'b0;
      fnd   <= 1'b0;
    end else begin
      tok <= tok_in;
      fnd <= fnd_in;
      if (shift) begin
        valid <= nxt_valid;
      end else if (write) begin
        valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      key    <= nxt_key;
      handle <= nxt_handle;
    end else if (write) begin
      key    <= enq_key;
      handle <= enq_handle;
    end
  end

endmodule
`default_nettype wire

### rtl/core/tag_matched_request_queue_unit.sv
`default_nettype none
// Enqueue: result strobed in the cycle after the beat is taken; busy stays low, so
// the next beat can be taken on the following cycle.
// Dequeue: a token sweeps the cell chain one cell per cycle from the oldest
// entry; busy holds the next beat off until the result is strobed.
// Reset clears all valid bits, the count and the sweep; entries need no clearing.
module tag_matched_request_queue_unit
  import tmrq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire req_t req,
  output logic      busy,
  output logic      strobe,
  output rsp_t      rsp
);

  logic       accept;
  logic       enq_we;
  logic       full;
  count_t     count;
  key_t       qry_key;
  handle_t    hold;
  key_t       in_key;
  handle_t    in_handle;

  logic       cv   [SLOTS];
  key_t       ck   [SLOTS];
  handle_t    ch   [SLOTS];
  logic       ctok [SLOTS];
  logic       cfnd [SLOTS];
  cell_stat_t cst  [SLOTS];

  logic       done;
  logic       found;
  logic       hit_any;
  handle_t    hit_hdl;
  handle_t    res_hdl;

  assign accept    = start && !busy;
  assign full      = (count == count_t'(SLOTS));
  assign enq_we    = accept && (req.opcode == OP_ENQ) && !full;
  assign in_key    = make_key(req);
  assign in_handle = req.request_handle[HANDLE_BITS-1:0];

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    logic    p_valid;
    logic    t_in;
    logic    f_in;
    logic    n_valid;
    key_t    n_key;
    handle_t n_hdl;

    if (i == 0) begin : g_head
      assign p_valid = 1'b1;
      assign t_in    = accept && (req.opcode == OP_DEQ);
      assign f_in    = 1'b0;
    end else begin : g_body
      assign p_valid = cv[i-1];
      assign t_in    = ctok[i-1];
      assign f_in    = cfnd[i-1];
    end

    if (i == SLOTS - 1) begin : g_tail
      assign n_valid = 1'b0;
      assign n_key   = '0;
      assign n_hdl   = '0;
    end else begin : g_link
      assign n_valid = cv[i+1];
      assign n_key   = ck[i+1];
      assign n_hdl   = ch[i+1];
    end

    tmrq_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .enq_we     (enq_we),
      .enq_key    (in_key),
      .enq_handle (in_handle),
      .qry_key    (qry_key),
      .prev_valid (p_valid),
      .tok_in     (t_in),
      .fnd_in     (f_in),
      .nxt_valid  (n_valid),
      .nxt_key    (n_key),
      .nxt_handle (n_hdl),
      .tok_out    (ctok[i]),
      .fnd_out    (cfnd[i]),
      .valid      (cv[i]),
      .key        (ck[i]),
      .handle     (ch[i]),
      .stat       (cst[i])
    );
  end

  always_comb begin
    done    = cst[SLOTS-1].tok;
    found   = 1'b0;
    hit_any = 1'b0;
    hit_hdl = '0;
    for (int i = 0; i < SLOTS; i++) begin
      done    = done | (cst[i].tok & ~cst[i].valid);
      found   = found | cst[i].acc;
      hit_any = hit_any | cst[i].hit;
      hit_hdl = hit_hdl | (cst[i].hit ? ch[i] : handle_t'(0));
    end
    res_hdl = hold | hit_hdl;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      strobe <= 1'b0;
      count  <= '0;
    end else begin
      strobe <= 1'b0;
      if (accept) begin
        if (req.opcode == OP_ENQ) begin
          strobe <= 1'b1;
          if (!full) begin
            count <= count + count_t'(1);
          end
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && done) begin
        busy   <= 1'b0;
        strobe <= 1'b1;
        if (found) begin
          count <= count - count_t'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      qry_key <= in_key;
      hold    <= '0;
      if (req.opcode == OP_ENQ) begin
        rsp.status        <= full ? ST_FULL : ST_OK;
        rsp.found_handle  <= '0;
        rsp.pending_count <= full ? 7'(count) : 7'(count + count_t'(1));
      end
    end else if (busy) begin
      if (hit_any) begin
        hold <= res_hdl;
      end
      if (done) begin
        rsp.status        <= found ? ST_OK : ST_MISS;
        rsp.found_handle  <= found ? 16'(res_hdl) : 16'd0;
        rsp.pending_count <= found ? 7'(count - count_t'(1)) : 7'(count);
      end
    end
  end

  logic [SLOTS-1:0] tok_vec;
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      tok_vec[i] = cst[i].tok;
    end
  end

  a_one_token: assert property (@(posedge clk) disable iff (rst) $onehot0(tok_vec))
    else $error("more than one sweep token in the chain");

  a_token_busy: assert property (@(posedge clk) disable iff (rst) (tok_vec != '0) |-> busy)
    else $error("sweep token present while idle");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= count_t'(SLOTS))
    else $error("pending count beyond store size");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    (strobe && rsp.status == ST_FULL) |-> (count == count_t'(SLOTS)))
    else $error("full status with free slots");

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst) strobe |-> !busy)
    else $error("result beat during a sweep");

endmodule
`default_nettype wire
